[sv/ptsc_pkg.sv]
// Shared types, sizes and codes for the projected timestamp cache.
`default_nettype none

package ptsc_pkg;

  localparam int SLOTS     = 16;
  localparam int BANKS     = 4;
  localparam int BANK_SIZE = SLOTS + 1;
  localparam int ENTRIES   = BANKS * BANK_SIZE;
  localparam int ENT_W     = $clog2(ENTRIES);
  localparam int SUB_W     = $clog2(BANK_SIZE);

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] CFG_DISC_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_SLEW_WINDOW = 2'd1;
  localparam logic [1:0] CFG_SLEW_LIMIT  = 2'd2;

  localparam logic [31:0] RST_DISC_LIMIT  = 32'd100000;
  localparam logic [31:0] RST_SLEW_WINDOW = 32'd250000;
  localparam logic [31:0] RST_SLEW_LIMIT  = 32'd50000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        clock_kind;
    logic        is_output;
    logic        use_fallback;
    logic [15:0] slot_index;
    logic [63:0] time_in;
    logic        uncertain_in;
    logic [63:0] now_ns;
    logic        now_valid;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] time_out;
    logic        uncertain_out;
    logic [31:0] update_count_out;
    logic        jump_flag;
  } result_t;

  typedef struct packed {
    logic [63:0] stored_time;
    logic [63:0] capture_time;
    logic        capture_valid;
    logic        uncertain_mark;
    logic [31:0] update_count;
  } entry_t;

  typedef struct packed {
    logic [31:0] discontinuity_limit;
    logic [31:0] slew_window;
    logic [31:0] slew_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic             rd_en;
    logic [ENT_W-1:0] rd_addr;
    logic             wr_en;
    logic [ENT_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

[sv/ptsc_entry_mem.sv]
// Entry store: one synchronous memory with a registered read port and a write port.
`default_nettype none

module ptsc_entry_mem (
  input  wire               clk,
  input  ptsc_pkg::mem_req_t req,
  output ptsc_pkg::entry_t   rd_data
);

  ptsc_pkg::entry_t mem [ptsc_pkg::ENTRIES];
  ptsc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/ptsc_core.sv]
// Sequencer and datapath: reads an entry, projects, measures error, slews and, for a set, writes back.
`default_nettype none

module ptsc_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ptsc_pkg::in_item_t  in_data,
  input  ptsc_pkg::cfg_regs_t cfg,
  input  wire                 res_ready,
  output logic                res_valid,
  output ptsc_pkg::result_t   res_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DELTA = 3'd1;
  localparam logic [2:0] ST_PROJ  = 3'd2;
  localparam logic [2:0] ST_ERR   = 3'd3;
  localparam logic [2:0] ST_ADJ   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic accept;
  logic [ptsc_pkg::ENT_W-1:0] in_idx;
  logic [ptsc_pkg::SUB_W-1:0] in_sub;
  logic in_reject;

  // Entry valid bits and "count has been written" bits live in flip-flops.
  logic [ptsc_pkg::ENTRIES-1:0] ent_vld_r, ent_vld_nxt;
  logic [ptsc_pkg::ENTRIES-1:0] cnt_vld_r, cnt_vld_nxt;

  ptsc_pkg::in_item_t item_r;
  logic [ptsc_pkg::ENT_W-1:0] idx_r;
  logic reject_r, ent_hit_r, cnt_hit_r;
  logic [63:0] delta_r, proj_r, mag_r;
  logic ge_r, neg_r, slew_r, jump_r;
  logic [31:0] adj_r;

  ptsc_pkg::mem_req_t mem_req;
  ptsc_pkg::entry_t   rd_data;

  logic [64:0] delta_full, diff_a, diff_b;
  logic err_en, proj_add;
  logic [31:0] cnt_cur;
  logic [63:0] store;
  logic is_set;

  ptsc_entry_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid & ~in_stall;

  assign in_sub = in_data.use_fallback ? ptsc_pkg::SUB_W'(ptsc_pkg::SLOTS)
                                       : in_data.slot_index[ptsc_pkg::SUB_W-1:0];
  assign in_idx = ptsc_pkg::ENT_W'({in_data.clock_kind, in_data.is_output}) *
                  ptsc_pkg::ENT_W'(ptsc_pkg::BANK_SIZE) + ptsc_pkg::ENT_W'(in_sub);
  assign in_reject = (in_data.opcode == ptsc_pkg::OP_NONE) ||
                     (!in_data.use_fallback &&
                      in_data.slot_index >= 16'(ptsc_pkg::SLOTS));

  // Error is only measured against an entry with a usable capture time.
  assign err_en   = ent_hit_r & item_r.now_valid & rd_data.capture_valid;
  assign proj_add = item_r.now_valid & rd_data.capture_valid & ge_r;
  assign cnt_cur  = cnt_hit_r ? rd_data.update_count : 32'd0;
  assign is_set   = (item_r.opcode == ptsc_pkg::OP_SET) && !reject_r;

  assign delta_full = {1'b0, item_r.now_ns} - {1'b0, rd_data.capture_time};
  assign diff_a     = {1'b0, item_r.time_in} - {1'b0, proj_r};
  assign diff_b     = {1'b0, proj_r} - {1'b0, item_r.time_in};

  always_comb begin
    if (!slew_r) begin
      store = item_r.time_in;
    end else if (!neg_r) begin
      store = proj_r + 64'(adj_r);
    end else if (proj_r > 64'(adj_r)) begin
      store = proj_r - 64'(adj_r);
    end else begin
      store = 64'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_DELTA;
      ST_DELTA: state_nxt = ST_PROJ;
      ST_PROJ:  state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_ADJ;
      ST_ADJ:   state_nxt = ST_FIN;
      ST_FIN:   if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req.rd_en   = accept;
    mem_req.rd_addr = in_idx;
    mem_req.wr_en   = (state_r == ST_FIN) && res_ready && is_set;
    mem_req.wr_addr = idx_r;
    mem_req.wr_data.stored_time    = store;
    mem_req.wr_data.capture_time   = item_r.now_ns;
    mem_req.wr_data.capture_valid  = item_r.now_valid;
    mem_req.wr_data.uncertain_mark = item_r.uncertain_in;
    mem_req.wr_data.update_count   = cnt_cur + 32'd1;
  end

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    cnt_vld_nxt = cnt_vld_r;
    if (accept && !in_reject && in_data.opcode == ptsc_pkg::OP_CLEAR) begin
      if (in_data.use_fallback) begin
        for (int b = 0; b < ptsc_pkg::BANKS; b++) begin
          for (int s = 0; s < ptsc_pkg::BANK_SIZE; s++) begin
            if ({in_data.clock_kind, in_data.is_output} == 2'(b)) begin
              ent_vld_nxt[b * ptsc_pkg::BANK_SIZE + s] = 1'b0;
            end
          end
        end
      end else begin
        ent_vld_nxt[in_idx] = 1'b0;
      end
    end
    if (mem_req.wr_en) begin
      ent_vld_nxt[idx_r] = 1'b1;
      cnt_vld_nxt[idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ent_vld_r <= '0;
      cnt_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      ent_vld_r <= ent_vld_nxt;
      cnt_vld_r <= cnt_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_data;
      idx_r     <= in_idx;
      reject_r  <= in_reject;
      ent_hit_r <= ent_vld_r[in_idx];
      cnt_hit_r <= cnt_vld_r[in_idx];
    end
    if (state_r == ST_DELTA) begin
      delta_r <= delta_full[63:0];
      ge_r    <= ~delta_full[64];
    end
    if (state_r == ST_PROJ) begin
      proj_r <= rd_data.stored_time + (proj_add ? delta_r : 64'd0);
    end
    if (state_r == ST_ERR) begin
      neg_r <= diff_a[64];
      mag_r <= diff_a[64] ? diff_b[63:0] : diff_a[63:0];
    end
    if (state_r == ST_ADJ) begin
      adj_r  <= (mag_r[63:3] > 61'(cfg.slew_limit)) ? cfg.slew_limit : mag_r[34:3];
      slew_r <= err_en & item_r.clock_kind & item_r.is_output & ~item_r.uncertain_in &
                (mag_r <= 64'(cfg.slew_window));
      jump_r <= err_en & (mag_r > 64'(cfg.discontinuity_limit));
    end
  end

  assign res_valid = (state_r == ST_FIN);

  always_comb begin
    res_data = '0;
    if (!reject_r) begin
      case (item_r.opcode)
        ptsc_pkg::OP_SET: begin
          res_data.ok               = 1'b1;
          res_data.time_out         = store;
          res_data.uncertain_out    = item_r.uncertain_in;
          res_data.update_count_out = cnt_cur + 32'd1;
          res_data.jump_flag        = jump_r;
        end
        ptsc_pkg::OP_GET: begin
          if (ent_hit_r) begin
            res_data.ok               = 1'b1;
            res_data.time_out         = proj_r;
            res_data.uncertain_out    = rd_data.uncertain_mark;
            res_data.update_count_out = cnt_cur;
          end
        end
        ptsc_pkg::OP_CLEAR: begin
          res_data.ok               = 1'b1;
          res_data.update_count_out = cnt_cur;
        end
        default: res_data = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/projected_timestamp_cache_slew_top.sv]
// Projected timestamp cache with output media-clock slewing: top level.
//
// Input beats on in_valid/in_stall/in_data carry one operation (set, get
// or clear) on one entry of four banks of timestamp entries. Each
// operation yields exactly one result beat on out_valid/out_stall/out_data.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and writes are meant for when the block is idle.
//
// An item is read from the entry memory at acceptance, then passes the
// elapsed-time, projection, error and adjustment states of the
// read-modify-write sequencer and ends in a final state where the entry is
// written back and the result register is loaded in the same cycle. A new
// item is accepted only after the previous one has left the sequencer, and
// in_stall is high while an item is in the sequencer.
//
// If out_stall holds the result register full, the sequencer waits in its
// last step and the entry write-back waits with it. Synchronous active-low
// reset restores the register defaults and invalidates every entry at once;
// update counts read as zero until an entry is first set.
`default_nettype none

module projected_timestamp_cache_slew_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  ptsc_pkg::in_item_t in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output ptsc_pkg::result_t  out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_data
);

  ptsc_pkg::cfg_regs_t cfg_r;
  ptsc_pkg::result_t   out_data_r;
  logic                out_valid_r;
  logic                res_valid, res_ready;
  ptsc_pkg::result_t   res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.discontinuity_limit <= ptsc_pkg::RST_DISC_LIMIT;
      cfg_r.slew_window         <= ptsc_pkg::RST_SLEW_WINDOW;
      cfg_r.slew_limit          <= ptsc_pkg::RST_SLEW_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptsc_pkg::CFG_DISC_LIMIT:  cfg_r.discontinuity_limit <= cfg_data;
        ptsc_pkg::CFG_SLEW_WINDOW: cfg_r.slew_window         <= cfg_data;
        ptsc_pkg::CFG_SLEW_LIMIT:  cfg_r.slew_limit          <= cfg_data;
        default: ;
      endcase
    end
  end

  ptsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // The result register can take a new beat when empty or being drained.
  assign res_ready = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the projected timestamp cache with output media-clock slewing.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptsc_pkg::*;

  localparam int LATENCY     = 6;
  localparam int PER_PHASE   = 305;
  localparam int HOLD_CYCLES = 400;

  // Mirror of the entry banks and registers, and the queue of results still owed.
  class ts_cache_scoreboard;
    bit [63:0] stored_ns   [ENTRIES];
    bit [63:0] captured_ns [ENTRIES];
    bit        live        [ENTRIES];
    bit        capture_ok  [ENTRIES];
    bit        uncertain   [ENTRIES];
    bit [31:0] updates     [ENTRIES];
    bit [31:0] jump_limit;
    bit [31:0] window;
    bit [31:0] step_cap;
    result_t   pending_results[$];
    int        errors;

    function new();
      jump_limit = RST_DISC_LIMIT;
      window     = RST_SLEW_WINDOW;
      step_cap   = RST_SLEW_LIMIT;
      errors     = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_DISC_LIMIT:  jump_limit = val;
        CFG_SLEW_WINDOW: window = val;
        CFG_SLEW_LIMIT:  step_cap = val;
        default: ;
      endcase
    endfunction

    // Returns -1 for an addressed slot beyond the bank.
    function int entry_index(in_item_t it);
      if (!it.use_fallback && it.slot_index >= SLOTS) return -1;
      return int'({it.clock_kind, it.is_output}) * BANK_SIZE +
             (it.use_fallback ? SLOTS : int'(it.slot_index));
    endfunction

    function bit [63:0] project(int e, bit [63:0] now, bit now_ok);
      bit [63:0] p;
      p = stored_ns[e];
      if (now_ok && capture_ok[e] && now >= captured_ns[e]) p = p + (now - captured_ns[e]);
      return p;
    endfunction

    function void wipe(int e);
      stored_ns[e]   = '0;
      captured_ns[e] = '0;
      live[e]        = 1'b0;
      capture_ok[e]  = 1'b0;
      uncertain[e]   = 1'b0;
    endfunction

    function void note_item(in_item_t it);
      result_t   r;
      int        e;
      int        first;
      bit [63:0] proj;
      bit [63:0] mag;
      bit [63:0] adj;
      bit [63:0] store;
      bit        neg;
      r = '0;
      e = entry_index(it);
      if (it.opcode != OP_NONE && e >= 0) begin
        case (it.opcode)
          OP_SET: begin
            store = it.time_in;
            if (live[e] && it.now_valid && capture_ok[e]) begin
              proj = project(e, it.now_ns, 1'b1);
              neg  = it.time_in < proj;
              mag  = neg ? proj - it.time_in : it.time_in - proj;
              // Only a certain output media entry close to its projection gets nudged.
              if (it.clock_kind && it.is_output && !it.uncertain_in && mag <= window) begin
                adj = mag / 8;
                if (adj > step_cap) adj = step_cap;
                if (!neg) store = proj + adj;
                else store = (proj > adj) ? proj - adj : '0;
              end
              r.jump_flag = mag > jump_limit;
            end
            stored_ns[e]   = store;
            captured_ns[e] = it.now_ns;
            capture_ok[e]  = it.now_valid;
            uncertain[e]   = it.uncertain_in;
            live[e]        = 1'b1;
            updates[e]     = updates[e] + 1;
            r.ok               = 1'b1;
            r.time_out         = store;
            r.uncertain_out    = it.uncertain_in;
            r.update_count_out = updates[e];
          end
          OP_GET: begin
            if (live[e]) begin
              r.ok               = 1'b1;
              r.time_out         = project(e, it.now_ns, it.now_valid);
              r.uncertain_out    = uncertain[e];
              r.update_count_out = updates[e];
            end
          end
          OP_CLEAR: begin
            if (it.use_fallback) begin
              first = e - SLOTS;
              for (int i = 0; i < BANK_SIZE; i++) wipe(first + i);
            end else begin
              wipe(e);
            end
            r.ok               = 1'b1;
            r.update_count_out = updates[e];
          end
          default: ;
        endcase
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat with nothing expected: %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok got %b exp %b", got.ok, want.ok));
      if (got.time_out !== want.time_out)
        report($sformatf("time_out got %0d exp %0d", got.time_out, want.time_out));
      if (got.uncertain_out !== want.uncertain_out)
        report($sformatf("uncertain_out got %b exp %b", got.uncertain_out, want.uncertain_out));
      if (got.update_count_out !== want.update_count_out)
        report($sformatf("update_count_out got %0d exp %0d",
                         got.update_count_out, want.update_count_out));
      if (got.jump_flag !== want.jump_flag)
        report($sformatf("jump_flag got %b exp %b", got.jump_flag, want.jump_flag));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  result_t     out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  ts_cache_scoreboard sb = new();
  bit        calm;
  int        results_seen;
  bit [63:0] wall;

  projected_timestamp_cache_slew_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_item(in_data);
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results_seen++;
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int run;
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      run = calm ? 40 : $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (run) @(negedge clk);
      if (!held && results_seen > 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(negedge clk);
      end
    end
  end

  function automatic in_item_t op_item(logic [1:0] op, bit kind, bit side, bit fb,
                                       logic [15:0] slot, logic [63:0] t, bit unc,
                                       logic [63:0] now, bit now_ok);
    in_item_t it;
    it.opcode       = op;
    it.clock_kind   = kind;
    it.is_output    = side;
    it.use_fallback = fb;
    it.slot_index   = slot;
    it.time_in      = t;
    it.uncertain_in = unc;
    it.now_ns       = now;
    it.now_valid    = now_ok;
    return it;
  endfunction

  // Mostly updates near the current projection of a few hot entries, with some noise.
  function automatic in_item_t random_item();
    in_item_t  it;
    int        r;
    int        e;
    bit [63:0] err;
    bit [63:0] base;
    r = $urandom_range(0, 99);
    it.opcode = (r < 58) ? OP_SET : (r < 80) ? OP_GET : (r < 93) ? OP_CLEAR : OP_NONE;
    if ($urandom_range(0, 1)) begin
      it.clock_kind = 1'b1;
      it.is_output  = 1'b1;
    end else begin
      it.clock_kind = $urandom_range(0, 1);
      it.is_output  = $urandom_range(0, 1);
    end
    r = $urandom_range(0, 99);
    it.use_fallback = (r >= 80 && r < 90);
    if (it.use_fallback) it.slot_index = $urandom_range(0, 65535);
    else if (r < 80) it.slot_index = $urandom_range(0, 3);
    else if (r < 95) it.slot_index = $urandom_range(0, SLOTS - 1);
    else it.slot_index = $urandom_range(SLOTS, 65535);
    if ($urandom_range(0, 99) < 4) wall = {$urandom, $urandom};
    else wall = wall + $urandom_range(0, 2_000_000);
    it.now_ns       = wall;
    it.now_valid    = $urandom_range(0, 19) != 0;
    it.uncertain_in = $urandom_range(0, 6) == 0;
    e    = sb.entry_index(it);
    base = (e >= 0) ? sb.project(e, it.now_ns, it.now_valid) : 64'd0;
    r    = $urandom_range(0, 99);
    err  = (r < 45) ? $urandom_range(0, 2000) :
           (r < 80) ? $urandom_range(0, 600_000) : $urandom_range(0, 8_000_000);
    if (r >= 92) it.time_in = {$urandom, $urandom};
    else it.time_in = $urandom_range(0, 1) ? base + err : base - err;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [31:0] lim, input logic [31:0] win,
                            input logic [31:0] cap);
    logic [31:0] vals [3];
    logic [1:0]  idx  [3];
    vals = '{lim, win, cap};
    idx  = '{CFG_DISC_LIMIT, CFG_SLEW_WINDOW, CFG_SLEW_LIMIT};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    logic [31:0] plan [5][3];
    in_item_t    it;
    int          n;
    int          k;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DISC_LIMIT;
    cfg_data  = '0;
    calm      = 1'b0;
    wall      = '0;
    results_seen = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, under the reset register values.
    send(op_item(OP_GET,   1, 1, 0, 0, 0, 0, 0, 1));
    send(op_item(OP_SET,   1, 1, 0, 0, 64'd1_000_000, 0, 64'd0, 1));
    send(op_item(OP_SET,   1, 1, 0, 0, 64'd1_001_800, 0, 64'd1000, 1));
    send(op_item(OP_SET,   1, 1, 0, 0, 64'd842_100, 0, 64'd2000, 1));
    send(op_item(OP_SET,   1, 1, 0, 0, 64'd5_000_000, 0, 64'd3000, 1));
    send(op_item(OP_SET,   1, 1, 0, 0, 64'd5_001_500, 1, 64'd4000, 1));
    // Wall time behind the capture, then no wall time at all.
    send(op_item(OP_GET,   1, 1, 0, 0, 0, 0, 64'd100, 1));
    send(op_item(OP_GET,   1, 1, 0, 0, 0, 0, 64'd9000, 0));
    send(op_item(OP_SET,   1, 1, 0, 0, 64'd7_000_000, 0, 64'd9000, 0));
    send(op_item(OP_SET,   1, 1, 0, 0, 64'd7_000_400, 0, 64'd9500, 1));
    // Projection that wraps past the top of the time range.
    send(op_item(OP_SET,   0, 0, 0, 15, '1, 0, 64'd5, 1));
    send(op_item(OP_GET,   0, 0, 0, 15, 0, 1, '1, 1));
    send(op_item(OP_SET,   0, 1, 1, 16'hFFFF, 0, 1, '1, 1));
    send(op_item(OP_GET,   0, 1, 1, 0, 0, 0, '1, 1));
    send(op_item(OP_SET,   1, 0, 0, 16, 64'd123, 0, 64'd10, 1));
    send(op_item(OP_GET,   1, 0, 0, 16'hFFFF, 0, 0, 0, 1));
    send(op_item(OP_NONE,  1, 1, 0, 0, '1, 1, '1, 1));
    send(op_item(OP_CLEAR, 1, 1, 0, 0, 0, 0, 0, 0));
    send(op_item(OP_GET,   1, 1, 0, 0, 0, 0, 64'd9600, 1));
    send(op_item(OP_SET,   1, 0, 0, 3, 64'd42, 0, 64'd20, 1));
    send(op_item(OP_CLEAR, 1, 0, 1, 16'hFFFF, 0, 0, 0, 1));
    send(op_item(OP_GET,   1, 0, 0, 3, 0, 0, 64'd30, 1));
    send(op_item(OP_CLEAR, 0, 0, 0, 20, 0, 0, 0, 1));
    send(op_item(OP_SET,   1, 1, 1, 0, 64'd100, 0, 64'd0, 1));
    send(op_item(OP_SET,   1, 1, 1, 0, 64'd5, 0, 64'd0, 1));

    plan = '{'{RST_DISC_LIMIT, RST_SLEW_WINDOW, RST_SLEW_LIMIT},
             '{32'd0, 32'd0, 32'd0},
             '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
             '{32'd1000, 32'd4_000_000, 32'd100},
             '{$urandom_range(0, 1_000_000), $urandom_range(0, 2_000_000),
               $urandom_range(0, 300_000)}};
    k = 0;
    for (int p = 0; p < 5; p++) begin
      settle();
      write_regs(plan[p][0], plan[p][1], plan[p][2]);
      n = 0;
      while (n < PER_PHASE) begin
        it = random_item();
        n++;
        k++;
        if (k % 60 == 0) calm = ($urandom_range(0, 3) == 0);
        send(it);
      end
    end

    settle();
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
